/* rtl/core/queued_lock_manager_defines.svh */
// ----------------------------------------------------------------------------
// Queued lock manager assertion macros
// Clocked assertion shorthands shared by the lock manager RTL.
// ----------------------------------------------------------------------------
`ifndef QUEUED_LOCK_MANAGER_DEFINES_SVH
`define QUEUED_LOCK_MANAGER_DEFINES_SVH

// Expression must hold at every clock edge out of reset.
`define QLM_ASSERT_ALWAYS(lbl, expr, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) else $error(msg);

// Antecedent implies consequent on the same edge.
`define QLM_ASSERT_IMPL(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Antecedent implies consequent on the following edge.
`define QLM_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

/* rtl/core/qlm_pkg.sv */
// ----------------------------------------------------------------------------
// Queued lock manager package
// Field widths, request and status codes, and the result word layout.
// ----------------------------------------------------------------------------
package qlm_pkg;

  localparam int unsigned LOCK_W     = 6;
  localparam int unsigned CLIENT_W   = 4;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned IN_DATA_W  = 16;
  localparam int unsigned OUT_DATA_W = 16;

  localparam logic OP_ACQUIRE = 1'b0;
  localparam logic OP_RELEASE = 1'b1;

  localparam logic [STATUS_W-1:0] ST_OK           = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RETRY        = 2'd1;
  localparam logic [STATUS_W-1:0] ST_FREE_RELEASE = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FULL         = 2'd3;

  typedef struct packed {
    logic [CLIENT_W-1:0] revoke_client;
    logic                revoke_valid;
    logic [CLIENT_W-1:0] retry_client;
    logic                retry_valid;
    logic [STATUS_W-1:0] status;
  } res_t;

endpackage

/* rtl/core/queued_lock_manager.sv */
// ----------------------------------------------------------------------------
// Queued lock manager
// Lock table with one owner and a FIFO of waiting clients per lock.
// ----------------------------------------------------------------------------
//  channel | dir | tdata (low bit up)                        | tuser
//  --------+-----+-------------------------------------------+--------
//  in_     | in  | lock_id[5:0], client_id[9:6], 0 pad        | opcode
//  out_    | out | status[1:0], retry_valid[2],               | -
//          |     | retry_client[6:3], revoke_valid[7],        |
//          |     | revoke_client[11:8], 0 pad                 |
//
//  Each request passes the table RAM read, then the entry update, write-back
//  and result register. A new word enters every cycle while no result stalls;
//  a write-through on the RAM read port covers same-lock neighbors. After
//  reset a sweep clears the lock table with in_tready low. A stalled result
//  holds the update stage, which then holds in_tready low.
// ----------------------------------------------------------------------------
`include "queued_lock_manager_defines.svh"

module queued_lock_manager #(
  parameter int unsigned NUM_LOCKS   = 64,
  parameter int unsigned QUEUE_DEPTH = 4
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  output logic                             in_tready,
  // lock_id[5:0], client_id[9:6], zero pad
  input  logic [qlm_pkg::IN_DATA_W-1:0]    in_tdata,
  // opcode
  input  logic                             in_tuser,
  output logic                             out_tvalid,
  input  logic                             out_tready,
  // status[1:0], retry_valid, retry_client[6:3], revoke_valid,
  // revoke_client[11:8], zero pad
  output logic [qlm_pkg::OUT_DATA_W-1:0]   out_tdata
);

  localparam int unsigned CW     = qlm_pkg::CLIENT_W;
  localparam int unsigned LW     = qlm_pkg::LOCK_W;
  localparam int unsigned LIDX_W = $clog2(NUM_LOCKS);
  localparam int unsigned HD_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W  = $clog2(QUEUE_DEPTH + 1);
  localparam int unsigned ENT_W  = 1 + CW + HD_W + CNT_W;
  localparam int unsigned ROW_W  = QUEUE_DEPTH * CW;
  localparam int unsigned RES_W  = $bits(qlm_pkg::res_t);

  // lock_id reduced modulo NUM_LOCKS
  logic [LIDX_W-1:0] lmod_tbl [2**LW];
  for (genvar g = 0; g < 2**LW; g++) begin : g_lmod
    localparam int unsigned LMOD = g % NUM_LOCKS;
    assign lmod_tbl[g] = LIDX_W'(LMOD);
  end

  logic [LW-1:0]     in_lock_id;
  logic [CW-1:0]     in_client_id;
  logic [LIDX_W-1:0] in_lk_idx;
  logic              acc;
  logic              adv;

  logic              clr_active_r;
  logic [LIDX_W-1:0] clr_addr_r;

  logic              stg_v_r;
  logic              stg_op_r;
  logic [CW-1:0]     stg_cl_r;
  logic [LIDX_W-1:0] stg_lk_r;

  logic              out_v_r;
  qlm_pkg::res_t     out_res_r;

  logic [ENT_W-1:0]  ent_rd;
  logic [ENT_W-1:0]  ent_new;
  logic [ENT_W-1:0]  ent_wdata;
  logic [LIDX_W-1:0] ent_waddr;
  logic              ent_we;
  logic [ROW_W-1:0]  row_rd;
  logic [ROW_W-1:0]  row_new;

  logic              upd_st_we;
  logic              upd_slot_we;
  logic              upd_held;
  logic [CW-1:0]     upd_owner;
  logic [HD_W-1:0]   upd_head;
  logic [CNT_W-1:0]  upd_count;
  qlm_pkg::res_t     upd_res;

  assign in_lock_id   = in_tdata[LW-1:0];
  assign in_client_id = in_tdata[LW+CW-1:LW];
  assign in_lk_idx    = lmod_tbl[in_lock_id];

  assign adv       = stg_v_r && (!out_v_r || out_tready);
  assign in_tready = !clr_active_r && (!stg_v_r || adv);
  assign acc       = in_tvalid && in_tready;

  // clear sweep over the lock table after reset
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      clr_active_r <= 1'b1;
      clr_addr_r   <= '0;
    end else if (clr_active_r) begin
      clr_addr_r <= clr_addr_r + LIDX_W'(1);
      if (clr_addr_r == LIDX_W'(NUM_LOCKS - 1)) begin
        clr_active_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
    end else if (acc) begin
      stg_v_r <= 1'b1;
    end else if (adv) begin
      stg_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      stg_op_r <= in_tuser;
      stg_cl_r <= in_client_id;
      stg_lk_r <= in_lk_idx;
    end
  end

  assign ent_we    = clr_active_r || (adv && upd_st_we);
  assign ent_waddr = clr_active_r ? clr_addr_r : stg_lk_r;
  assign ent_new   = {upd_held, upd_owner, upd_head, upd_count};
  assign ent_wdata = clr_active_r ? '0 : ent_new;

  qlm_ram #(
    .DEPTH (NUM_LOCKS),
    .WIDTH (ENT_W)
  ) u_lock_ram (
    .clk   (clk),
    .we    (ent_we),
    .waddr (ent_waddr),
    .wdata (ent_wdata),
    .re    (acc),
    .raddr (in_lk_idx),
    .rdata (ent_rd)
  );

  qlm_ram #(
    .DEPTH (NUM_LOCKS),
    .WIDTH (ROW_W)
  ) u_slot_ram (
    .clk   (clk),
    .we    (adv && upd_slot_we),
    .waddr (stg_lk_r),
    .wdata (row_new),
    .re    (acc),
    .raddr (in_lk_idx),
    .rdata (row_rd)
  );

  qlm_update #(
    .QUEUE_DEPTH (QUEUE_DEPTH)
  ) u_update (
    .op      (stg_op_r),
    .client  (stg_cl_r),
    .held_i  (ent_rd[ENT_W-1]),
    .owner_i (ent_rd[ENT_W-2:HD_W+CNT_W]),
    .head_i  (ent_rd[HD_W+CNT_W-1:CNT_W]),
    .count_i (ent_rd[CNT_W-1:0]),
    .slots_i (row_rd),
    .st_we   (upd_st_we),
    .held_o  (upd_held),
    .owner_o (upd_owner),
    .head_o  (upd_head),
    .count_o (upd_count),
    .slot_we (upd_slot_we),
    .slots_o (row_new),
    .res     (upd_res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_v_r <= 1'b0;
    end else if (adv) begin
      out_v_r <= 1'b1;
    end else if (out_tready) begin
      out_v_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_res_r <= upd_res;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_tdata  = {(qlm_pkg::OUT_DATA_W - RES_W)'(0), out_res_r};

  `QLM_ASSERT_IMPL(a_no_accept_in_clear, clr_active_r, !in_tready, "word accepted during table clear")
  `QLM_ASSERT_IMPL(a_hold_when_stalled, stg_v_r && !adv, !in_tready, "stage overrun while stalled")
  `QLM_ASSERT_NEXT(a_result_follows, adv, out_tvalid, "finished request left no result")
  `QLM_ASSERT_ALWAYS(a_full_is_silent, !(out_v_r && (out_res_r.status == qlm_pkg::ST_FULL) && (out_res_r.retry_valid || out_res_r.revoke_valid)), "full status carries a notice")
  `QLM_ASSERT_IMPL(a_pair_same_client, out_v_r && out_res_r.retry_valid && out_res_r.revoke_valid, out_res_r.retry_client == out_res_r.revoke_client, "retry and revoke name different clients")

endmodule

/* rtl/core/qlm_ram.sv */
// ----------------------------------------------------------------------------
// Queued lock manager table RAM
// One write port, one registered read port; a read at the address being
// written in the same cycle returns the new data.
// ----------------------------------------------------------------------------
module qlm_ram #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned WIDTH = 8,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      if (we && (waddr == raddr)) begin
        rdata_r <= wdata;
      end else begin
        rdata_r <= mem[raddr];
      end
    end
  end

  assign rdata = rdata_r;

endmodule

/* rtl/core/qlm_update.sv */
// ----------------------------------------------------------------------------
// Queued lock manager entry update
// Next lock entry, wait ring row and result for one acquire or release.
// ----------------------------------------------------------------------------
module qlm_update #(
  parameter int unsigned QUEUE_DEPTH = 4,
  localparam int unsigned CW    = qlm_pkg::CLIENT_W,
  localparam int unsigned HD_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1,
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1)
) (
  input  logic                               op,
  input  logic [CW-1:0]                      client,
  input  logic                               held_i,
  input  logic [CW-1:0]                      owner_i,
  input  logic [HD_W-1:0]                    head_i,
  input  logic [CNT_W-1:0]                   count_i,
  input  logic [QUEUE_DEPTH-1:0][CW-1:0]     slots_i,
  output logic                               st_we,
  output logic                               held_o,
  output logic [CW-1:0]                      owner_o,
  output logic [HD_W-1:0]                    head_o,
  output logic [CNT_W-1:0]                   count_o,
  output logic                               slot_we,
  output logic [QUEUE_DEPTH-1:0][CW-1:0]     slots_o,
  output qlm_pkg::res_t                      res
);

  logic [CNT_W:0]   tail_sum;
  logic [CNT_W:0]   tail_wrap;
  logic [HD_W-1:0]  tail_idx;
  logic [HD_W:0]    head_inc;
  logic [CNT_W-1:0] count_dec;
  logic [CW-1:0]    head_client;

  always_comb begin
    tail_sum = (CNT_W+1)'(head_i) + (CNT_W+1)'(count_i);
    if (tail_sum >= (CNT_W+1)'(QUEUE_DEPTH)) begin
      tail_wrap = tail_sum - (CNT_W+1)'(QUEUE_DEPTH);
    end else begin
      tail_wrap = tail_sum;
    end
    tail_idx = tail_wrap[HD_W-1:0];

    head_inc = (HD_W+1)'(head_i) + (HD_W+1)'(1);
    if (head_inc == (HD_W+1)'(QUEUE_DEPTH)) begin
      head_inc = '0;
    end

    count_dec   = count_i - CNT_W'(1);
    head_client = slots_i[head_i];
  end

  always_comb begin
    st_we   = 1'b0;
    held_o  = held_i;
    owner_o = owner_i;
    head_o  = head_i;
    count_o = count_i;
    slot_we = 1'b0;
    slots_o = slots_i;
    res     = '0;
    res.status = qlm_pkg::ST_OK;

    case (op)
      qlm_pkg::OP_ACQUIRE: begin
        if (!held_i) begin
          st_we   = 1'b1;
          held_o  = 1'b1;
          owner_o = client;
        end else if (count_i == CNT_W'(QUEUE_DEPTH)) begin
          res.status = qlm_pkg::ST_FULL;
        end else begin
          // enqueue at the ring tail; the first waiter triggers a revoke
          st_we   = 1'b1;
          slot_we = 1'b1;
          slots_o[tail_idx] = client;
          count_o = count_i + CNT_W'(1);
          res.status = qlm_pkg::ST_RETRY;
          if (count_i == '0) begin
            res.revoke_valid  = 1'b1;
            res.revoke_client = owner_i;
          end
        end
      end
      qlm_pkg::OP_RELEASE: begin
        if (!held_i) begin
          res.status = qlm_pkg::ST_FREE_RELEASE;
        end else if (count_i != '0) begin
          // hand over to the head waiter
          st_we   = 1'b1;
          head_o  = head_inc[HD_W-1:0];
          count_o = count_dec;
          owner_o = head_client;
          res.retry_valid  = 1'b1;
          res.retry_client = head_client;
          if (count_dec != '0) begin
            res.revoke_valid  = 1'b1;
            res.revoke_client = head_client;
          end
        end else begin
          st_we   = 1'b1;
          held_o  = 1'b0;
          owner_o = '0;
        end
      end
      default: begin
        res.status = qlm_pkg::ST_OK;
      end
    endcase
  end

endmodule

/* test/queued_lock_manager_tb.sv */
// ----------------------------------------------------------------------------
// Queued lock manager testbench
// Sends acquire and release words to the lock table over the input stream.
// A local copy of the lock table predicts each reply that a directed row
// does not fix, and the testbench compares each whole reply word with the
// expected one. A short directed table covers the extremes, full queues,
// ring wrap and free releases. A random run on a few busy locks follows.
// Both stream sides idle at random, and one long result stall backs the
// block up.
module queued_lock_manager_tb;

  localparam int unsigned NUM_LOCKS   = 64;
  localparam int unsigned QUEUE_DEPTH = 4;
  localparam int unsigned RANDOM_REQS = 600;
  localparam int unsigned HOLD_CYCLES = 300;
  localparam int unsigned IDLE_PCT    = 34;
  localparam int unsigned CYCLE_LIMIT = 200000;

  typedef struct {
    logic                         op;
    logic [qlm_pkg::LOCK_W-1:0]   lock;
    logic [qlm_pkg::CLIENT_W-1:0] client;
    bit                           fixed;
    qlm_pkg::res_t                want;
  } req_row_t;

  logic                           clk;
  logic                           rst_n      = 1'b0;
  logic                           in_tvalid  = 1'b0;
  logic                           in_tready;
  logic [qlm_pkg::IN_DATA_W-1:0]  in_tdata   = '0;
  logic                           in_tuser   = qlm_pkg::OP_ACQUIRE;
  logic                           out_tvalid;
  logic                           out_tready = 1'b0;
  logic [qlm_pkg::OUT_DATA_W-1:0] out_tdata;

  // local copy of the lock table
  bit                           lock_held   [NUM_LOCKS];
  logic [qlm_pkg::CLIENT_W-1:0] lock_owner  [NUM_LOCKS];
  logic [qlm_pkg::CLIENT_W-1:0] waiter_slot [NUM_LOCKS][QUEUE_DEPTH];
  int unsigned                  waiter_head [NUM_LOCKS];
  int unsigned                  waiter_count[NUM_LOCKS];

  qlm_pkg::res_t pending_replies[$];
  req_row_t      directed[$];
  int unsigned   mismatch_count = 0;
  int unsigned   cycle_count    = 0;
  bit            tx_steady      = 1'b0;
  bit            rx_steady      = 1'b0;
  bit            hold_req       = 1'b0;
  int unsigned   hold_left      = 0;
  logic [qlm_pkg::LOCK_W-1:0] hot_locks[4];

  queued_lock_manager #(
    .NUM_LOCKS  (NUM_LOCKS),
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_tdata  (in_tdata),
    .in_tuser  (in_tuser),
    .out_tvalid(out_tvalid),
    .out_tready(out_tready),
    .out_tdata (out_tdata)
  );

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  initial begin : watchdog
    wait (cycle_count >= CYCLE_LIMIT);
    $display("== FAIL ==");
    $finish;
  end

  function automatic qlm_pkg::res_t make_reply(logic [qlm_pkg::STATUS_W-1:0] st, logic rtv,
                                               logic [qlm_pkg::CLIENT_W-1:0] rtc, logic rvv,
                                               logic [qlm_pkg::CLIENT_W-1:0] rvc);
    qlm_pkg::res_t r;
    r.status        = st;
    r.retry_valid   = rtv;
    r.retry_client  = rtc;
    r.revoke_valid  = rvv;
    r.revoke_client = rvc;
    return r;
  endfunction

  // Update the lock table for one request and return the reply it causes.
  function automatic qlm_pkg::res_t apply_lock_request(logic op,
                                                       logic [qlm_pkg::LOCK_W-1:0] lock_idx,
                                                       logic [qlm_pkg::CLIENT_W-1:0] client);
    qlm_pkg::res_t                r;
    int unsigned                  lk;
    int unsigned                  tail;
    logic [qlm_pkg::CLIENT_W-1:0] heir;
    lk = lock_idx % NUM_LOCKS;
    r  = make_reply(qlm_pkg::ST_OK, 1'b0, '0, 1'b0, '0);
    if (op == qlm_pkg::OP_ACQUIRE) begin
      if (!lock_held[lk]) begin
        lock_held[lk]  = 1'b1;
        lock_owner[lk] = client;
      end else if (waiter_count[lk] >= QUEUE_DEPTH) begin
        r.status = qlm_pkg::ST_FULL;
      end else begin
        tail = (waiter_head[lk] + waiter_count[lk]) % QUEUE_DEPTH;
        // first waiter: ask the owner to give the lock back
        if (waiter_count[lk] == 0) begin
          r.revoke_valid  = 1'b1;
          r.revoke_client = lock_owner[lk];
        end
        waiter_slot[lk][tail] = client;
        waiter_count[lk]++;
        r.status = qlm_pkg::ST_RETRY;
      end
    end else begin
      if (!lock_held[lk]) begin
        r.status = qlm_pkg::ST_FREE_RELEASE;
      end else if (waiter_count[lk] != 0) begin
        heir             = waiter_slot[lk][waiter_head[lk]];
        waiter_head[lk]  = (waiter_head[lk] + 1) % QUEUE_DEPTH;
        waiter_count[lk]--;
        lock_owner[lk]   = heir;
        r.retry_valid    = 1'b1;
        r.retry_client   = heir;
        if (waiter_count[lk] != 0) begin
          r.revoke_valid  = 1'b1;
          r.revoke_client = heir;
        end
      end else begin
        lock_held[lk]  = 1'b0;
        lock_owner[lk] = '0;
      end
    end
    return r;
  endfunction

  // Offer one request word, wait for the handshake, then queue the expected reply.
  task automatic send_request(logic op, logic [qlm_pkg::LOCK_W-1:0] lock_idx,
                              logic [qlm_pkg::CLIENT_W-1:0] client, bit fixed,
                              qlm_pkg::res_t want);
    qlm_pkg::res_t modeled;
    if (!tx_steady && $urandom_range(0, 99) < IDLE_PCT) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while (!tx_steady && $urandom_range(0, 99) < IDLE_PCT);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{(qlm_pkg::IN_DATA_W-qlm_pkg::LOCK_W-qlm_pkg::CLIENT_W){1'b0}},
                  client, lock_idx};
    do @(posedge clk); while (!in_tready);
    modeled = apply_lock_request(op, lock_idx, client);
    pending_replies.push_back(fixed ? want : modeled);
  endtask

  task automatic add_row(logic op, logic [qlm_pkg::LOCK_W-1:0] lock_idx,
                         logic [qlm_pkg::CLIENT_W-1:0] client);
    req_row_t row;
    row.op     = op;
    row.lock   = lock_idx;
    row.client = client;
    row.fixed  = 1'b0;
    row.want   = make_reply(qlm_pkg::ST_OK, 1'b0, '0, 1'b0, '0);
    directed.push_back(row);
  endtask

  task automatic add_fixed_row(logic op, logic [qlm_pkg::LOCK_W-1:0] lock_idx,
                               logic [qlm_pkg::CLIENT_W-1:0] client, qlm_pkg::res_t want);
    req_row_t row;
    row.op     = op;
    row.lock   = lock_idx;
    row.client = client;
    row.fixed  = 1'b1;
    row.want   = want;
    directed.push_back(row);
  endtask

  // result side: random stalls, steady stretch, and one long hold-off
  initial begin : reply_sink
    forever begin
      @(posedge clk);
      if (hold_req && hold_left == 0) begin
        hold_left = HOLD_CYCLES;
        hold_req  = 1'b0;
      end
      if (hold_left != 0) begin
        out_tready <= 1'b0;
        hold_left--;
      end else if (rx_steady) begin
        out_tready <= 1'b1;
      end else begin
        out_tready <= ($urandom_range(0, 99) >= IDLE_PCT);
      end
    end
  end

  always @(posedge clk) begin
    qlm_pkg::res_t got;
    qlm_pkg::res_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got = qlm_pkg::res_t'(out_tdata[$bits(qlm_pkg::res_t)-1:0]);
      if (pending_replies.size() == 0) begin
        mismatch_count++;
        if (mismatch_count <= 10)
          $display("reply word with nothing pending: status=%0d rt=%0b/%0d rv=%0b/%0d",
                   got.status, got.retry_valid, got.retry_client,
                   got.revoke_valid, got.revoke_client);
      end else begin
        want = pending_replies.pop_front();
        if (got !== want) begin
          mismatch_count++;
          if (mismatch_count <= 10)
            $display({"reply mismatch: want status=%0d rt=%0b/%0d rv=%0b/%0d, ",
                      "got status=%0d rt=%0b/%0d rv=%0b/%0d"},
                     want.status, want.retry_valid, want.retry_client,
                     want.revoke_valid, want.revoke_client,
                     got.status, got.retry_valid, got.retry_client,
                     got.revoke_valid, got.revoke_client);
        end
      end
    end
  end

  initial begin : stimulus
    qlm_pkg::res_t                no_reply;
    logic                         op;
    logic [qlm_pkg::LOCK_W-1:0]   lk;
    logic [qlm_pkg::CLIENT_W-1:0] cl;
    int unsigned                  settle;

    no_reply = make_reply(qlm_pkg::ST_OK, 1'b0, '0, 1'b0, '0);
    for (int i = 0; i < NUM_LOCKS; i++) begin
      lock_held[i]    = 1'b0;
      lock_owner[i]   = '0;
      waiter_head[i]  = 0;
      waiter_count[i] = 0;
    end

    // release of free locks, top lock filled to a full queue, ring wrap
    add_fixed_row(qlm_pkg::OP_RELEASE, 6'd0,  4'd0,
                  make_reply(qlm_pkg::ST_FREE_RELEASE, 1'b0, '0, 1'b0, '0));
    add_fixed_row(qlm_pkg::OP_RELEASE, 6'd63, 4'd15,
                  make_reply(qlm_pkg::ST_FREE_RELEASE, 1'b0, '0, 1'b0, '0));
    add_fixed_row(qlm_pkg::OP_ACQUIRE, 6'd63, 4'd15, no_reply);
    add_fixed_row(qlm_pkg::OP_ACQUIRE, 6'd63, 4'd0,
                  make_reply(qlm_pkg::ST_RETRY, 1'b0, '0, 1'b1, 4'd15));
    // owner asks again: queued like anyone else
    add_fixed_row(qlm_pkg::OP_ACQUIRE, 6'd63, 4'd15,
                  make_reply(qlm_pkg::ST_RETRY, 1'b0, '0, 1'b0, '0));
    add_row(qlm_pkg::OP_ACQUIRE, 6'd63, 4'd7);
    add_row(qlm_pkg::OP_ACQUIRE, 6'd63, 4'd9);
    add_fixed_row(qlm_pkg::OP_ACQUIRE, 6'd63, 4'd3,
                  make_reply(qlm_pkg::ST_FULL, 1'b0, '0, 1'b0, '0));
    add_row(qlm_pkg::OP_RELEASE, 6'd63, 4'd15);
    // non-owner release acts for the owner
    add_row(qlm_pkg::OP_RELEASE, 6'd63, 4'd5);
    add_row(qlm_pkg::OP_RELEASE, 6'd63, 4'd7);
    add_row(qlm_pkg::OP_ACQUIRE, 6'd63, 4'd1);
    add_row(qlm_pkg::OP_RELEASE, 6'd63, 4'd9);
    add_row(qlm_pkg::OP_RELEASE, 6'd63, 4'd1);
    add_row(qlm_pkg::OP_RELEASE, 6'd63, 4'd1);
    add_fixed_row(qlm_pkg::OP_RELEASE, 6'd63, 4'd1,
                  make_reply(qlm_pkg::ST_FREE_RELEASE, 1'b0, '0, 1'b0, '0));
    add_fixed_row(qlm_pkg::OP_ACQUIRE, 6'd0,  4'd0,  no_reply);
    add_fixed_row(qlm_pkg::OP_ACQUIRE, 6'd0,  4'd0,
                  make_reply(qlm_pkg::ST_RETRY, 1'b0, '0, 1'b1, 4'd0));
    add_row(qlm_pkg::OP_RELEASE, 6'd0,  4'd0);
    add_row(qlm_pkg::OP_RELEASE, 6'd0,  4'd0);
    add_row(qlm_pkg::OP_ACQUIRE, 6'd42, 4'd10);
    add_row(qlm_pkg::OP_ACQUIRE, 6'd21, 4'd5);
    add_row(qlm_pkg::OP_RELEASE, 6'd42, 4'd10);
    add_row(qlm_pkg::OP_RELEASE, 6'd21, 4'd5);

    repeat (10) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed[i])
      send_request(directed[i].op, directed[i].lock, directed[i].client,
                   directed[i].fixed, directed[i].want);

    for (int n = 0; n < RANDOM_REQS; n++) begin
      // move the busy set now and then so many locks see deep queues
      if (n % 100 == 0)
        foreach (hot_locks[k])
          hot_locks[k] = qlm_pkg::LOCK_W'($urandom_range(0, NUM_LOCKS - 1));
      if (n == 200) hold_req = 1'b1;
      tx_steady = (n >= 350 && n < 450);
      rx_steady = (n >= 350 && n < 450);
      op = ($urandom_range(0, 1) == 0) ? qlm_pkg::OP_ACQUIRE : qlm_pkg::OP_RELEASE;
      if ($urandom_range(0, 99) < 75)
        lk = hot_locks[$urandom_range(0, 3)];
      else
        lk = qlm_pkg::LOCK_W'($urandom_range(0, NUM_LOCKS - 1));
      cl = qlm_pkg::CLIENT_W'($urandom_range(0, 15));
      send_request(op, lk, cl, 1'b0, no_reply);
    end
    tx_steady = 1'b0;
    rx_steady = 1'b0;
    in_tvalid <= 1'b0;

    while (pending_replies.size() != 0) @(posedge clk);
    // catch stray words after the last reply
    for (settle = 0; settle < 20; settle++) @(posedge clk);

    if (mismatch_count == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
